>>> rtl/cir_pkg.sv
// Shared types, constants and the divide-by-three step of the tap power analyzer.
package cir_pkg;

	localparam int unsigned TAPS       = 64;
	localparam int unsigned LEAD_END   = 8;
	localparam int unsigned TAIL_BEGIN = 40;

	localparam int CNT_W   = 7;
	localparam int IDX_W   = 6;
	localparam int RAW_W   = 48;
	localparam int PART_W  = 18;
	localparam int IQ_W    = 16;
	localparam int PWR_W   = 36;
	localparam int LEAD_W  = 39;
	localparam int TAIL_W  = 40;

	localparam int DIV_BITS   = 8;
	localparam int DIV_STAGES = TAIL_W / DIV_BITS;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [IQ_W-1:0]   iq_real;
		logic [IQ_W-1:0]   iq_imag;
		logic [PART_W-1:0] mag_re;
		logic [PART_W-1:0] mag_im;
		logic              acc_en;
		logic              in_lead;
		logic              in_tail;
		logic              last;
		logic [IDX_W-1:0]  idx;
	} tap_req_t;

	typedef struct packed {
		logic              valid;
		tap_req_t          data;
	} req_chan_t;

	typedef struct packed {
		logic [IQ_W-1:0]   iq_real;
		logic [IQ_W-1:0]   iq_imag;
		logic [PWR_W-1:0]  tap_power;
		logic              summary_valid;
		logic [PWR_W-1:0]  lead_mean;
		logic [TAIL_W-1:0] tail_work;
		logic [1:0]        rem;
		logic [PWR_W-1:0]  peak_pwr;
		logic [IDX_W-1:0]  peak_tap;
	} res_t;

	// One pipeline step of long division by three, DIV_BITS quotient bits from the top.
	// Quotient bits replace the dividend bits in place as they are produced.
	function automatic res_t div3_step(input res_t d, input logic [2:0] stg);
		res_t             r;
		logic [2:0]       t;
		logic [5:0]       pos;
		r = d;
		for (int j = 0; j < DIV_BITS; j++) begin
			pos = 6'(TAIL_W - 1 - DIV_BITS * int'(stg) - j);
			t = {r.rem, r.tail_work[pos]};
			if (t >= 3'd3) begin
				r.tail_work[pos] = 1'b1;
				r.rem = 2'(t - 3'd3);
			end else begin
				r.tail_work[pos] = 1'b0;
				r.rem = t[1:0];
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/cir_front.sv
// Front end: takes tap requests, unpacks I/Q, forms magnitudes and classifies the tap position.
module cir_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cir_pkg::RAW_W-1:0]     tap_raw,
	input  logic                          last_tap,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          q_full,
	output cir_pkg::req_chan_t            push
);

	logic [cir_pkg::CNT_W-1:0]  tap_count_q;
	logic [cir_pkg::PART_W-1:0] re;
	logic [cir_pkg::PART_W-1:0] im;
	logic                       take;

	assign re       = tap_raw[17:0];
	assign im       = tap_raw[41:24];
	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	always_comb begin
		push.valid             = take;
		push.data.iq_real      = re[17:2];
		push.data.iq_imag      = im[17:2];
		push.data.mag_re       = re[17] ? (~re + 18'd1) : re;
		push.data.mag_im       = im[17] ? (~im + 18'd1) : im;
		push.data.acc_en       = tap_count_q < cir_pkg::CNT_W'(cir_pkg::TAPS);
		push.data.in_lead      = tap_count_q < cir_pkg::CNT_W'(cir_pkg::LEAD_END);
		push.data.in_tail      = tap_count_q >= cir_pkg::CNT_W'(cir_pkg::TAIL_BEGIN);
		push.data.last         = last_tap;
		push.data.idx          = tap_count_q[cir_pkg::IDX_W-1:0];
	end

	// The position counter saturates at TAPS and restarts after the last tap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= '0;
		end else if (take) begin
			if (last_tap) begin
				tap_count_q <= '0;
			end else if (push.data.acc_en) begin
				tap_count_q <= tap_count_q + 7'd1;
			end
		end
	end

endmodule

>>> rtl/cir_fifo.sv
// Short request queue between the front end and the back end.
module cir_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cir_pkg::req_chan_t   push,
	output logic                 full,
	input  logic                 pop,
	output cir_pkg::req_chan_t   head
);

	cir_pkg::tap_req_t           mem_q [cir_pkg::QDEPTH];
	logic [cir_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [cir_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [cir_pkg::QCNT_W-1:0]  count_q;
	logic                        do_pop;

	assign full       = count_q == cir_pkg::QCNT_W'(cir_pkg::QDEPTH);
	assign head.valid = count_q != '0;
	assign head.data  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 3'd1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 3'd1;
			end
		end
	end

endmodule

>>> rtl/cir_back.sv
// Back end: squares, power sum, record accumulation, tail division and the output register.
module cir_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cir_pkg::req_chan_t     head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output cir_pkg::res_t          res
);

	logic                          adv;

	// Stage 1: squares of the magnitudes.
	logic                          vld_s1;
	cir_pkg::tap_req_t             req_s1;
	logic [cir_pkg::PWR_W-1:0]     sq_re_s1;
	logic [cir_pkg::PWR_W-1:0]     sq_im_s1;

	// Stage 2: tap power.
	logic                          vld_s2;
	cir_pkg::tap_req_t             req_s2;
	logic [cir_pkg::PWR_W-1:0]     pwr_s2;

	// Record state.
	logic [cir_pkg::LEAD_W-1:0]    lead_acc_q;
	logic [cir_pkg::TAIL_W-1:0]    tail_acc_q;
	logic [cir_pkg::PWR_W-1:0]     best_power_q;
	logic [cir_pkg::IDX_W-1:0]     best_tap_q;

	logic [cir_pkg::LEAD_W-1:0]    lead_nx;
	logic [cir_pkg::TAIL_W-1:0]    tail_nx;
	logic [cir_pkg::PWR_W-1:0]     best_nx;
	logic [cir_pkg::IDX_W-1:0]     best_tap_nx;
	logic                          acc_step;
	cir_pkg::res_t                 res_nx;

	// Stage 3 and the division stages after it; the last entry is the output register.
	logic                          vld_s [cir_pkg::DIV_STAGES+1];
	cir_pkg::res_t                 res_s [cir_pkg::DIV_STAGES+1];

	// The whole pipeline moves as one when the output register can take a new result.
	assign adv       = !vld_s[cir_pkg::DIV_STAGES] || !out_stall;
	assign pop       = head.valid && adv;
	assign out_valid = vld_s[cir_pkg::DIV_STAGES];
	assign res       = res_s[cir_pkg::DIV_STAGES];
	assign acc_step  = vld_s2 && adv;

	always_comb begin
		lead_nx     = lead_acc_q;
		tail_nx     = tail_acc_q;
		best_nx     = best_power_q;
		best_tap_nx = best_tap_q;
		if (req_s2.acc_en) begin
			if (req_s2.in_lead) begin
				lead_nx = lead_acc_q + cir_pkg::LEAD_W'(pwr_s2);
			end
			if (req_s2.in_tail) begin
				tail_nx = tail_acc_q + cir_pkg::TAIL_W'(pwr_s2);
			end
			if (pwr_s2 > best_power_q) begin
				best_nx     = pwr_s2;
				best_tap_nx = req_s2.idx;
			end
		end

		res_nx.iq_real       = req_s2.iq_real;
		res_nx.iq_imag       = req_s2.iq_imag;
		res_nx.tap_power     = pwr_s2;
		res_nx.summary_valid = req_s2.last;
		res_nx.rem           = '0;
		if (req_s2.last) begin
			res_nx.lead_mean  = lead_nx[cir_pkg::LEAD_W-1:3];
			res_nx.tail_work  = {3'b000, tail_nx[cir_pkg::TAIL_W-1:3]};
			res_nx.peak_pwr   = best_nx;
			res_nx.peak_tap   = best_tap_nx;
		end else begin
			res_nx.lead_mean  = '0;
			res_nx.tail_work  = '0;
			res_nx.peak_pwr   = '0;
			res_nx.peak_tap   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k <= cir_pkg::DIV_STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
			lead_acc_q   <= '0;
			tail_acc_q   <= '0;
			best_power_q <= '0;
			best_tap_q   <= '0;
		end else begin
			if (adv) begin
				vld_s1   <= head.valid;
				vld_s2   <= vld_s1;
				vld_s[0] <= vld_s2;
				for (int k = 1; k <= cir_pkg::DIV_STAGES; k++) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
			if (acc_step) begin
				if (req_s2.last) begin
					lead_acc_q   <= '0;
					tail_acc_q   <= '0;
					best_power_q <= '0;
					best_tap_q   <= '0;
				end else begin
					lead_acc_q   <= lead_nx;
					tail_acc_q   <= tail_nx;
					best_power_q <= best_nx;
					best_tap_q   <= best_tap_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1   <= head.data;
			sq_re_s1 <= cir_pkg::PWR_W'(head.data.mag_re) * cir_pkg::PWR_W'(head.data.mag_re);
			sq_im_s1 <= cir_pkg::PWR_W'(head.data.mag_im) * cir_pkg::PWR_W'(head.data.mag_im);
			req_s2   <= req_s1;
			pwr_s2   <= sq_re_s1 + sq_im_s1;
			res_s[0] <= res_nx;
			for (int k = 1; k <= cir_pkg::DIV_STAGES; k++) begin
				res_s[k] <= cir_pkg::div3_step(res_s[k-1], 3'(k - 1));
			end
		end
	end

endmodule

>>> rtl/cir_tap_power_peak_analyzer_core.sv
// Top level of the channel impulse response tap power and peak analyzer.
// The block takes one tap per cycle while in_stall is low and returns one result per tap,
// in order, after the tap leaves the four-entry request queue and passes the squares
// register, the power-sum register, the record-accumulation register and the stages
// of the tail-mean division by three, which retires eight quotient bits per stage. The
// sustained rate is one tap per clock; in_stall rises only when the queue is full,
// which happens when out_stall holds the result pipeline still. On the tap marked
// last the summary fields carry the lead mean, tail mean, peak power and peak
// position of the record, and the record state is cleared for the next one.
module cir_tap_power_peak_analyzer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cir_pkg::RAW_W-1:0]         tap_raw,
	input  logic                              last_tap,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [cir_pkg::IQ_W-1:0]   iq_real,
	output logic signed [cir_pkg::IQ_W-1:0]   iq_imag,
	output logic [cir_pkg::PWR_W-1:0]         tap_power,
	output logic                              summary_valid,
	output logic [cir_pkg::PWR_W-1:0]         lead_mean,
	output logic [cir_pkg::PWR_W-1:0]         tail_mean,
	output logic [cir_pkg::PWR_W-1:0]         peak_power_out,
	output logic [cir_pkg::IDX_W-1:0]         peak_tap
);

	cir_pkg::req_chan_t  push;
	cir_pkg::req_chan_t  head;
	cir_pkg::res_t       res;
	logic                q_full;
	logic                pop;

	cir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tap_raw  (tap_raw),
		.last_tap (last_tap),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.q_full   (q_full),
		.push     (push)
	);

	cir_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	cir_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign iq_real        = res.iq_real;
	assign iq_imag        = res.iq_imag;
	assign tap_power      = res.tap_power;
	assign summary_valid  = res.summary_valid;
	assign lead_mean      = res.lead_mean;
	assign tail_mean      = res.tail_work[cir_pkg::PWR_W-1:0];
	assign peak_power_out = res.peak_pwr;
	assign peak_tap       = res.peak_tap;

endmodule

>>> test/tb_cir_tap_power_peak_analyzer_core.sv
// Self-checking testbench of the tap power and peak analyzer: directed records, then random records.
module tb_cir_tap_power_peak_analyzer_core;

	localparam int HANG_LIMIT = 4000;
	localparam int RANDOM_TAPS = 1000;
	localparam int DRAIN_CYCLES = 16;

	localparam logic [cir_pkg::PART_W-1:0] PART_MIN = 18'h20000;
	localparam logic [cir_pkg::PART_W-1:0] PART_MAX = 18'h1FFFF;
	localparam logic [cir_pkg::PART_W-1:0] PART_NEG1 = 18'h3FFFF;

	typedef enum int { REC_NORMAL, REC_ZERO, REC_FULL } rec_kind_t;

	typedef struct packed {
		logic [cir_pkg::IQ_W-1:0]  iq_real;
		logic [cir_pkg::IQ_W-1:0]  iq_imag;
		logic [cir_pkg::PWR_W-1:0] tap_power;
		logic                      summary_valid;
		logic [cir_pkg::PWR_W-1:0] lead_mean;
		logic [cir_pkg::PWR_W-1:0] tail_mean;
		logic [cir_pkg::PWR_W-1:0] peak_pwr;
		logic [cir_pkg::IDX_W-1:0] peak_tap;
	} tap_result_t;

	class tap_result_tracker;
		tap_result_t                pending[$];
		logic [cir_pkg::CNT_W-1:0]  tap_pos;
		logic [cir_pkg::LEAD_W-1:0] lead_sum;
		logic [cir_pkg::TAIL_W-1:0] tail_sum;
		logic [cir_pkg::PWR_W-1:0]  best_power;
		logic [cir_pkg::IDX_W-1:0]  best_pos;
		int                         errors;
		int                         taps_seen;
		int                         summaries_seen;
		int                         taps_past_limit;

		function new();
			clear_record();
			errors = 0;
			taps_seen = 0;
			summaries_seen = 0;
			taps_past_limit = 0;
		endfunction

		function void clear_record();
			tap_pos = '0;
			lead_sum = '0;
			tail_sum = '0;
			best_power = '0;
			best_pos = '0;
		endfunction

		function int pending_count();
			return pending.size();
		endfunction

		// Works out the result of one tap and advances the record state.
		function tap_result_t predict_tap(logic [cir_pkg::RAW_W-1:0] raw, logic is_last);
			tap_result_t                r;
			logic [cir_pkg::PART_W-1:0] re;
			logic [cir_pkg::PART_W-1:0] im;
			logic [cir_pkg::PART_W-1:0] mag_re;
			logic [cir_pkg::PART_W-1:0] mag_im;
			logic [cir_pkg::PWR_W-1:0]  pwr;
			re = raw[cir_pkg::PART_W-1:0];
			im = raw[24 +: cir_pkg::PART_W];
			mag_re = re[cir_pkg::PART_W-1] ? -re : re;
			mag_im = im[cir_pkg::PART_W-1] ? -im : im;
			pwr = cir_pkg::PWR_W'(mag_re) * cir_pkg::PWR_W'(mag_re)
				+ cir_pkg::PWR_W'(mag_im) * cir_pkg::PWR_W'(mag_im);
			r = '0;
			r.iq_real = re[cir_pkg::PART_W-1:2];
			r.iq_imag = im[cir_pkg::PART_W-1:2];
			r.tap_power = pwr;
			if (tap_pos < cir_pkg::TAPS) begin
				if (tap_pos < cir_pkg::LEAD_END)
					lead_sum = lead_sum + cir_pkg::LEAD_W'(pwr);
				if (tap_pos >= cir_pkg::TAIL_BEGIN)
					tail_sum = tail_sum + cir_pkg::TAIL_W'(pwr);
				// Only a strictly larger power moves the peak, so the first maximum stays.
				if (pwr > best_power) begin
					best_power = pwr;
					best_pos = tap_pos[cir_pkg::IDX_W-1:0];
				end
				tap_pos = tap_pos + 1'b1;
			end else begin
				taps_past_limit++;
			end
			if (is_last) begin
				r.summary_valid = 1'b1;
				r.lead_mean = cir_pkg::PWR_W'(lead_sum / 8);
				r.tail_mean = cir_pkg::PWR_W'(tail_sum / 24);
				r.peak_pwr = best_power;
				r.peak_tap = best_pos;
				clear_record();
			end
			return r;
		endfunction

		function void note_tap(logic [cir_pkg::RAW_W-1:0] raw, logic is_last);
			pending.push_back(predict_tap(raw, is_last));
			taps_seen++;
		endfunction

		function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(tap_result_t act);
			tap_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: result with no request waiting, actual %0h", $time, act);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (exp_r.summary_valid)
				summaries_seen++;
			check_field("iq_real", 64'(exp_r.iq_real), 64'(act.iq_real));
			check_field("iq_imag", 64'(exp_r.iq_imag), 64'(act.iq_imag));
			check_field("tap_power", 64'(exp_r.tap_power), 64'(act.tap_power));
			check_field("summary_valid", 64'(exp_r.summary_valid),
				64'(act.summary_valid));
			check_field("lead_mean", 64'(exp_r.lead_mean), 64'(act.lead_mean));
			check_field("tail_mean", 64'(exp_r.tail_mean), 64'(act.tail_mean));
			check_field("peak_power_out", 64'(exp_r.peak_pwr), 64'(act.peak_pwr));
			check_field("peak_tap", 64'(exp_r.peak_tap), 64'(act.peak_tap));
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic [cir_pkg::RAW_W-1:0]         tap_raw;
	logic                              last_tap;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [cir_pkg::IQ_W-1:0]   iq_real;
	logic signed [cir_pkg::IQ_W-1:0]   iq_imag;
	logic [cir_pkg::PWR_W-1:0]         tap_power;
	logic                              summary_valid;
	logic [cir_pkg::PWR_W-1:0]         lead_mean;
	logic [cir_pkg::PWR_W-1:0]         tail_mean;
	logic [cir_pkg::PWR_W-1:0]         peak_power_out;
	logic [cir_pkg::IDX_W-1:0]         peak_tap;

	tap_result_tracker tracker;
	int burst_left;
	int stall_mode;
	int stall_left;
	int overlong_records;

	cir_tap_power_peak_analyzer_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.tap_raw        (tap_raw),
		.last_tap       (last_tap),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.iq_real        (iq_real),
		.iq_imag        (iq_imag),
		.tap_power      (tap_power),
		.summary_valid  (summary_valid),
		.lead_mean      (lead_mean),
		.tail_mean      (tail_mean),
		.peak_power_out (peak_power_out),
		.peak_tap       (peak_tap)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Requests are noted before results are checked; a result never comes in the same cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_tap(tap_raw, last_tap);
			if (out_valid && !out_stall)
				tracker.check_result({iq_real, iq_imag, tap_power, summary_valid,
					lead_mean, tail_mean, peak_power_out, peak_tap});
		end
	end

	// The receiver switches between free flow, light stalls, heavy stalls and solid stalls.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = (stall_mode == 3) ? $urandom_range(1, 16) : $urandom_range(8, 40);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= 1'b1;
		endcase
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no request moved for %0d cycles", $time, HANG_LIMIT);
		$display("cir_tap_power_peak_analyzer_core regression: fail");
		$finish;
	end

	function automatic logic [cir_pkg::PART_W-1:0] rand_part();
		case ($urandom_range(0, 9))
			0: return PART_MIN;
			1: return PART_MAX;
			2: return '0;
			3: return PART_NEG1;
			4, 5: return cir_pkg::PART_W'($urandom_range(0, 8)) - cir_pkg::PART_W'(4);
			default: return cir_pkg::PART_W'($urandom);
		endcase
	endfunction

	function automatic logic [cir_pkg::RAW_W-1:0] pack_tap(
		logic [cir_pkg::PART_W-1:0] re,
		logic [cir_pkg::PART_W-1:0] im
	);
		return {6'($urandom), im, 6'($urandom), re};
	endfunction

	function automatic logic [cir_pkg::RAW_W-1:0] rand_tap(rec_kind_t kind);
		case (kind)
			REC_ZERO: return pack_tap('0, '0);
			REC_FULL: return pack_tap(PART_MIN, PART_MIN);
			default: return pack_tap(rand_part(), rand_part());
		endcase
	endfunction

	// Sends one tap, opening a new burst after a random gap when the current one is used up.
	task automatic send_tap(logic [cir_pkg::RAW_W-1:0] raw, logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
				: $urandom_range(1, 40);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		tap_raw <= raw;
		last_tap <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_count() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	initial begin
		int rec;
		int rec_len;
		int pick;
		int sent;
		rec_kind_t kind;
		tracker = new();
		burst_left = 0;
		stall_mode = 0;
		stall_left = 0;
		overlong_records = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		tap_raw = '0;
		last_tap = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extreme parts, with every unused bit set on the first tap.
		send_tap({6'h3F, PART_MIN, 6'h3F, PART_MIN}, 1'b0);
		send_tap(pack_tap(PART_MAX, PART_MAX), 1'b0);
		send_tap(pack_tap(PART_NEG1, '0), 1'b0);
		send_tap(pack_tap('0, PART_NEG1), 1'b1);
		// An all-zero record reports a peak at position zero.
		send_tap(pack_tap('0, '0), 1'b0);
		send_tap({6'h3F, 18'd0, 6'h3F, 18'd0}, 1'b1);
		// Equal powers: the first of them keeps the peak.
		send_tap(pack_tap(18'd1, '0), 1'b0);
		send_tap(pack_tap(18'd5, '0), 1'b0);
		send_tap(pack_tap('0, 18'd5), 1'b0);
		send_tap(pack_tap(-18'd5, '0), 1'b0);
		send_tap(pack_tap(18'd3, -18'd4), 1'b1);
		// A single-tap record.
		send_tap(pack_tap(PART_MAX, PART_MIN), 1'b1);
		drain_results();

		rec = 0;
		sent = 0;
		while (sent < RANDOM_TAPS) begin
			kind = REC_NORMAL;
			if (rec == 0) begin
				rec_len = cir_pkg::TAPS + 8;
			end else if (rec == 1) begin
				// Every tap at full power drives both means to their largest values.
				rec_len = cir_pkg::TAPS;
				kind = REC_FULL;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick <= 12)
					rec_len = cir_pkg::TAPS;
				else if (pick <= 16)
					rec_len = $urandom_range(1, cir_pkg::TAPS - 1);
				else if (pick <= 18)
					rec_len = $urandom_range(cir_pkg::TAPS + 1, cir_pkg::TAPS + 24);
				else
					rec_len = 1;
				if ($urandom_range(0, 19) == 0)
					kind = REC_ZERO;
			end
			if (rec_len > cir_pkg::TAPS)
				overlong_records++;
			for (int i = 0; i < rec_len; i++)
				send_tap(rand_tap(kind), i == rec_len - 1);
			sent += rec_len;
			rec++;
			if (rec == 8)
				drain_results();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d taps in %0d random records plus directed ones, %0d %s",
			tracker.taps_seen, rec, tracker.summaries_seen, "records summarized.");
		$display("%0d records ran past the tap limit (%0d taps dropped from the sums), %0d %s",
			overlong_records, tracker.taps_past_limit, tracker.errors, "mismatches.");
		if (tracker.errors == 0 && tracker.pending_count() == 0)
			$display("cir_tap_power_peak_analyzer_core regression: pass");
		else
			$display("cir_tap_power_peak_analyzer_core regression: fail");
		$finish;
	end

endmodule
